// ===== design/prtu_pkg.sv =====
`timescale 1ns / 1ps
package prtu_pkg;

  localparam int POS_FRAC_DEF   = 16;
  localparam int ANGLE_FRAC_DEF = 13;
  localparam int TRIG_BITS      = 30;
  localparam int CORDIC_STEPS   = 30;
  localparam int ZW             = 38;
  localparam int CW             = 34;

  localparam logic signed [ZW-1:0] PI_Q30      = 38'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 38'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

  localparam logic [2:0] FN_POINT   = 3'd0;
  localparam logic [2:0] FN_VECTOR  = 3'd1;
  localparam logic [2:0] FN_TWIST   = 3'd2;
  localparam logic [2:0] FN_INVERT  = 3'd3;
  localparam logic [2:0] FN_COMPOSE = 3'd4;

  typedef enum logic [2:0] {
    OP_POINT,
    OP_VECTOR,
    OP_TWIST,
    OP_INVERT,
    OP_COMPOSE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [15:0] ta;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [15:0] oa;
    logic signed [31:0] om;
  } item_t;

  typedef struct packed {
    item_t                item;
    logic signed [ZW-1:0] z;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 neg;
  } cst_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 38'sd843314856;
      1: r = 38'sd497837829;
      2: r = 38'sd263043836;
      3: r = 38'sd133525158;
      4: r = 38'sd67021686;
      5: r = 38'sd33543515;
      6: r = 38'sd16775850;
      7: r = 38'sd8388437;
      8: r = 38'sd4194282;
      9: r = 38'sd2097149;
      10: r = 38'sd1048575;
      11: r = 38'sd524287;
      12: r = 38'sd262143;
      13: r = 38'sd131071;
      14: r = 38'sd65535;
      15: r = 38'sd32767;
      16: r = 38'sd16383;
      17: r = 38'sd8191;
      18: r = 38'sd4095;
      19: r = 38'sd2047;
      20: r = 38'sd1023;
      21: r = 38'sd511;
      22: r = 38'sd255;
      23: r = 38'sd127;
      24: r = 38'sd63;
      25: r = 38'sd31;
      26: r = 38'sd15;
      27: r = 38'sd8;
      28: r = 38'sd4;
      29: r = 38'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
    logic signed [31:0] r;
    if (v > 58'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -58'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== design/prtu_front.sv =====
`timescale 1ns / 1ps
module prtu_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_func,
  input  logic signed [31:0]   in_tf_x,
  input  logic signed [31:0]   in_tf_y,
  input  logic signed [15:0]   in_tf_angle,
  input  logic signed [31:0]   in_op_x,
  input  logic signed [31:0]   in_op_y,
  input  logic signed [15:0]   in_op_angle,
  input  logic signed [31:0]   in_op_omega,
  input  logic                 q_full,
  output logic                 q_push,
  output prtu_pkg::item_t      q_item
);
  import prtu_pkg::*;

  op_t op;

  always_comb begin
    case (in_func)
      FN_POINT:   op = OP_POINT;
      FN_VECTOR:  op = OP_VECTOR;
      FN_TWIST:   op = OP_TWIST;
      FN_INVERT:  op = OP_INVERT;
      FN_COMPOSE: op = OP_COMPOSE;
      default:    op = OP_NONE;
    endcase
  end

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign q_item.op = op;
  assign q_item.tx = in_tf_x;
  assign q_item.ty = in_tf_y;
  assign q_item.ta = in_tf_angle;
  assign q_item.ox = in_op_x;
  assign q_item.oy = in_op_y;
  assign q_item.oa = in_op_angle;
  assign q_item.om = in_op_omega;

endmodule

// ===== design/prtu_queue.sv =====
`timescale 1ns / 1ps
module prtu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  prtu_pkg::item_t  push_item,
  input  logic             pop,
  output logic             full,
  output logic             nonempty,
  output prtu_pkg::item_t  head_item
);
  import prtu_pkg::*;

  item_t      mem_r [0:1];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign nonempty  = (cnt_r != 2'd0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/prtu_back.sv =====
`timescale 1ns / 1ps
module prtu_back #(
  parameter int POS_FRAC_BITS   = prtu_pkg::POS_FRAC_DEF,
  parameter int ANGLE_FRAC_BITS = prtu_pkg::ANGLE_FRAC_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_nonempty,
  input  prtu_pkg::item_t     q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_res_x,
  output logic signed [31:0]  out_res_y,
  output logic signed [15:0]  out_res_angle,
  output logic signed [31:0]  out_res_omega
);
  import prtu_pkg::*;

  localparam int     SH      = TRIG_BITS - ANGLE_FRAC_BITS;
  localparam longint PI_A_L  = (64'd3373259426 + (64'd1 << (SH - 1))) >> SH;
  localparam logic signed [19:0] PI_A  = 20'(PI_A_L);
  localparam logic signed [19:0] PI_2A = 20'(2 * PI_A_L);
  localparam logic signed [65:0] RND_T = 66'sd1 <<< (TRIG_BITS - 1);
  localparam logic signed [65:0] RND_P = 66'sd1 <<< (POS_FRAC_BITS - 1);

  function automatic cst_t cordic_step(input cst_t s, input int i);
    cst_t r;
    r = s;
    if (!s.z[ZW-1]) begin
      r.x = s.x - (s.y >>> i);
      r.y = s.y + (s.x >>> i);
      r.z = s.z - atan_q30(i);
    end else begin
      r.x = s.x + (s.y >>> i);
      r.y = s.y - (s.x >>> i);
      r.z = s.z + atan_q30(i);
    end
    return r;
  endfunction

  logic adv;
  cst_t cst_r   [0:CORDIC_STEPS];
  cst_t cst_nxt [0:CORDIC_STEPS];
  logic [CORDIC_STEPS:0] cv_r;
  logic m1_vld_r, m2_vld_r, out_vld_r;

  item_t              m1_item_r;
  logic signed [63:0] p_ac_r, p_bs_r, p_as_r, p_bc_r, p_tyw_r, p_txw_r;
  item_t              m2_item_r;
  logic signed [35:0] rot_x_r, rot_y_r;
  logic signed [57:0] tw_x_r, tw_y_r;
  logic signed [19:0] ang_r;
  logic signed [31:0] res_x_r, res_y_r, res_w_r;
  logic signed [15:0] res_a_r;

  logic signed [ZW-1:0] z0;
  logic signed [CW-1:0] sn, cs;
  logic signed [31:0]   s32, c32, opa, opb;
  logic signed [65:0]   sx, sy, twx, twy;
  logic signed [19:0]   ra;
  logic signed [57:0]   addx, addy, rx, ry;

  assign adv   = !(out_vld_r && out_stall);
  assign q_pop = adv && q_nonempty;

  always_comb begin
    z0 = ZW'(q_item.ta) <<< SH;
    cst_nxt[0].item = q_item;
    cst_nxt[0].x    = GAIN_Q30;
    cst_nxt[0].y    = '0;
    cst_nxt[0].z    = z0;
    cst_nxt[0].neg  = 1'b0;
    if (z0 > HALF_PI_Q30) begin
      cst_nxt[0].z   = z0 - PI_Q30;
      cst_nxt[0].neg = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      cst_nxt[0].z   = z0 + PI_Q30;
      cst_nxt[0].neg = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      cst_nxt[i+1] = cordic_step(cst_r[i], i);
    end
  end

  always_comb begin
    sn  = cst_r[CORDIC_STEPS].neg ? -cst_r[CORDIC_STEPS].y : cst_r[CORDIC_STEPS].y;
    cs  = cst_r[CORDIC_STEPS].neg ? -cst_r[CORDIC_STEPS].x : cst_r[CORDIC_STEPS].x;
    s32 = sn[31:0];
    c32 = cs[31:0];
    opa = (cst_r[CORDIC_STEPS].item.op == OP_INVERT) ? cst_r[CORDIC_STEPS].item.tx
                                                      : cst_r[CORDIC_STEPS].item.ox;
    opb = (cst_r[CORDIC_STEPS].item.op == OP_INVERT) ? cst_r[CORDIC_STEPS].item.ty
                                                      : cst_r[CORDIC_STEPS].item.oy;
  end

  always_comb begin
    if (m1_item_r.op == OP_INVERT) begin
      sx = -(66'(p_ac_r) + 66'(p_bs_r));
      sy = 66'(p_as_r) - 66'(p_bc_r);
    end else begin
      sx = 66'(p_ac_r) - 66'(p_bs_r);
      sy = 66'(p_as_r) + 66'(p_bc_r);
    end
    sx  = (sx + RND_T) >>> TRIG_BITS;
    sy  = (sy + RND_T) >>> TRIG_BITS;
    twx = (66'(p_tyw_r) + RND_P) >>> POS_FRAC_BITS;
    twy = (66'(p_txw_r) + RND_P) >>> POS_FRAC_BITS;
    case (m1_item_r.op)
      OP_INVERT: ra = -20'(m1_item_r.ta);
      OP_COMPOSE: begin
        ra = 20'(m1_item_r.ta) + 20'(m1_item_r.oa);
        if (ra > PI_A) ra = ra - PI_2A;
        if (ra > PI_A) ra = ra - PI_2A;
        if (ra <= -PI_A) ra = ra + PI_2A;
        if (ra <= -PI_A) ra = ra + PI_2A;
      end
      default: ra = '0;
    endcase
  end

  always_comb begin
    case (m2_item_r.op)
      OP_POINT, OP_COMPOSE: begin
        addx = 58'(m2_item_r.tx);
        addy = 58'(m2_item_r.ty);
      end
      OP_TWIST: begin
        addx = tw_x_r;
        addy = -tw_y_r;
      end
      default: begin
        addx = '0;
        addy = '0;
      end
    endcase
    rx = 58'(rot_x_r) + addx;
    ry = 58'(rot_y_r) + addy;
    if (m2_item_r.op == OP_NONE) begin
      rx = '0;
      ry = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r      <= '0;
      m1_vld_r  <= 1'b0;
      m2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      cv_r      <= {cv_r[CORDIC_STEPS-1:0], q_pop};
      m1_vld_r  <= cv_r[CORDIC_STEPS];
      m2_vld_r  <= m1_vld_r;
      out_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
        cst_r[i] <= cst_nxt[i];
      end
      m1_item_r <= cst_r[CORDIC_STEPS].item;
      p_ac_r    <= opa * c32;
      p_bs_r    <= opb * s32;
      p_as_r    <= opa * s32;
      p_bc_r    <= opb * c32;
      p_tyw_r   <= cst_r[CORDIC_STEPS].item.ty * cst_r[CORDIC_STEPS].item.om;
      p_txw_r   <= cst_r[CORDIC_STEPS].item.tx * cst_r[CORDIC_STEPS].item.om;
      m2_item_r <= m1_item_r;
      rot_x_r   <= sx[35:0];
      rot_y_r   <= sy[35:0];
      tw_x_r    <= twx[57:0];
      tw_y_r    <= twy[57:0];
      ang_r     <= ra;
      res_x_r   <= sat32(rx);
      res_y_r   <= sat32(ry);
      res_a_r   <= sat16(ang_r);
      res_w_r   <= (m2_item_r.op == OP_TWIST) ? m2_item_r.om : 32'sd0;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_res_x     = res_x_r;
  assign out_res_y     = res_y_r;
  assign out_res_angle = res_a_r;
  assign out_res_omega = res_w_r;

endmodule

// ===== design/planar_rigid_transform_unit.sv =====
`timescale 1ns / 1ps
// Requests pass the queue, the 30-stage CORDIC pipeline and the product, sum and output
// registers; throughput is one request per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline, and the two-entry queue in front of it
// takes up to two more requests before the input stalls.
// Reset is synchronous and active low and clears all valid and queue state.
module planar_rigid_transform_unit #(
  parameter int POS_FRAC_BITS   = prtu_pkg::POS_FRAC_DEF,
  parameter int ANGLE_FRAC_BITS = prtu_pkg::ANGLE_FRAC_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_func,
  input  logic signed [31:0]  in_tf_x,
  input  logic signed [31:0]  in_tf_y,
  input  logic signed [15:0]  in_tf_angle,
  input  logic signed [31:0]  in_op_x,
  input  logic signed [31:0]  in_op_y,
  input  logic signed [15:0]  in_op_angle,
  input  logic signed [31:0]  in_op_omega,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_res_x,
  output logic signed [31:0]  out_res_y,
  output logic signed [15:0]  out_res_angle,
  output logic signed [31:0]  out_res_omega
);
  import prtu_pkg::*;

  logic  q_full, q_push, q_pop, q_nonempty;
  item_t push_item, head_item;

  prtu_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_tf_x     (in_tf_x),
    .in_tf_y     (in_tf_y),
    .in_tf_angle (in_tf_angle),
    .in_op_x     (in_op_x),
    .in_op_y     (in_op_y),
    .in_op_angle (in_op_angle),
    .in_op_omega (in_op_omega),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  prtu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head_item (head_item)
  );

  prtu_back #(
    .POS_FRAC_BITS   (POS_FRAC_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_nonempty    (q_nonempty),
    .q_item        (head_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res_x     (out_res_x),
    .out_res_y     (out_res_y),
    .out_res_angle (out_res_angle),
    .out_res_omega (out_res_omega)
  );

endmodule

// ===== design/prtu_checker.sv =====
`timescale 1ns / 1ps
module prtu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_res_x,
  input logic signed [31:0] out_res_y,
  input logic signed [15:0] out_res_angle,
  input logic signed [31:0] out_res_omega
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_res_x) && $stable(out_res_y))
    else $error("stalled result changed");

  a_angle_omega_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res_omega != 32'sd0 |-> out_res_angle == 16'sd0)
    else $error("twist result carries an angle");

endmodule

bind planar_rigid_transform_unit prtu_checker u_prtu_checker (.*);
